>>> src/trial_division_prime_test_assert.svh
// ----------------------------------------------------------------------------
// Trial division prime test - assertion macros
// Concurrent assertion helpers; they compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TRIAL_DIVISION_PRIME_TEST_ASSERT_SVH
`define TRIAL_DIVISION_PRIME_TEST_ASSERT_SVH

`ifndef SYNTHESIS
// Check an implication on every rising clock edge outside reset.
`define TDPT_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: implication check failed");
// Check that a condition never holds outside reset.
`define TDPT_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define TDPT_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define TDPT_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

>>> src/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// Trial division prime test - package
// Field widths and default sizes shared by the interfaces and the modules.
// ----------------------------------------------------------------------------
package tdpt_pkg;

  // Payload field widths
  localparam int unsigned CAND_W   = 32;
  localparam int unsigned FACTOR_W = 32;

  // Default width of the number under test
  localparam int unsigned NUM_W_DEFAULT = 32;

  // First trial divisor and smallest prime
  localparam int unsigned SMALLEST_PRIME = 2;

endpackage

>>> src/tdpt_if.sv
// ----------------------------------------------------------------------------
// Trial division prime test - channel interfaces
// Valid/ready channels for the candidate item and the result item.
// ----------------------------------------------------------------------------
interface tdpt_in_if import tdpt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CAND_W-1:0] candidate;

  modport source (output valid, output candidate, input ready);
  modport sink   (input valid, input candidate, output ready);
endinterface

interface tdpt_out_if import tdpt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                is_prime;
  logic [FACTOR_W-1:0] least_factor;

  modport source (output valid, output is_prime, output least_factor, input ready);
  modport sink   (input valid, input is_prime, input least_factor, output ready);
endinterface

>>> src/trial_division_prime_test.sv
// A candidate of 0 or 1 skips the divider; otherwise the test runs k divisions,
// where k is the last divisor tried minus one (about sqrt(n)).
// Worst case for NUM_WIDTH = 32 is about 65535 divisions.
// Throughput: one item at a time; the serial divider sets the cost of each trial divisor.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and drops any held result.
// ----------------------------------------------------------------------------
// Trial division prime test - top level
// Tests one unsigned candidate per item for primality by trial division and
// returns a prime flag together with the smallest divisor found.
// ----------------------------------------------------------------------------
`include "trial_division_prime_test_assert.svh"

module trial_division_prime_test import tdpt_pkg::*; #(
  parameter int unsigned NUM_WIDTH = NUM_W_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tdpt_in_if.sink    in_i,
  tdpt_out_if.source out_o
);

  // Sequencer codes
  localparam logic [1:0] ST_IDLE = 2'd0;  // wait for an item
  localparam logic [1:0] ST_RUN  = 2'd1;  // one trial division in flight
  localparam logic [1:0] ST_FIN  = 2'd2;  // result ready, wait for the output register

  localparam logic [NUM_WIDTH-1:0] FIRST_DIV = NUM_WIDTH'(SMALLEST_PRIME);

  logic [1:0]           state_q, state_d;
  logic [NUM_WIDTH-1:0] num_q, num_d;        // number under test
  logic [NUM_WIDTH-1:0] dvs_q, dvs_d;        // current trial divisor
  logic                 res_prime_q, res_prime_d;
  logic [NUM_WIDTH-1:0] res_factor_q, res_factor_d;

  logic                 out_valid_q, out_valid_d;
  logic                 out_prime_q, out_prime_d;
  logic [FACTOR_W-1:0]  out_factor_q, out_factor_d;

  logic [NUM_WIDTH-1:0] cand_n;
  logic [FACTOR_W-1:0]  factor_fit;
  logic                 in_accept;
  logic                 out_load;
  logic                 out_free;

  logic                 div_start;
  logic [NUM_WIDTH-1:0] div_dividend;
  logic [NUM_WIDTH-1:0] div_divisor;
  logic                 div_done;
  logic [NUM_WIDTH-1:0] div_quot;
  logic [NUM_WIDTH-1:0] div_rem;

  // Fit the candidate to the working width: drop upper bits or zero-extend
  if (NUM_WIDTH > CAND_W) begin : g_cand_ext
    assign cand_n = {{(NUM_WIDTH - CAND_W){1'b0}}, in_i.candidate};
  end else begin : g_cand_trunc
    assign cand_n = in_i.candidate[NUM_WIDTH-1:0];
  end

  // Fit the factor to the result field: mask or zero-extend
  if (NUM_WIDTH >= FACTOR_W) begin : g_fac_trunc
    assign factor_fit = res_factor_q[FACTOR_W-1:0];
  end else begin : g_fac_ext
    assign factor_fit = {{(FACTOR_W - NUM_WIDTH){1'b0}}, res_factor_q};
  end

  // Accept only while idle; the output register parts the result side
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_accept  = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign out_load   = (state_q == ST_FIN) && out_free;

  tdpt_div #(
    .NUM_WIDTH (NUM_WIDTH)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  always_comb begin
    state_d      = state_q;
    num_d        = num_q;
    dvs_d        = dvs_q;
    res_prime_d  = res_prime_q;
    res_factor_d = res_factor_q;
    div_start    = 1'b0;
    div_dividend = num_q;
    div_divisor  = dvs_q;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          num_d = cand_n;
          if (cand_n < FIRST_DIV) begin
            // Zero and one: not prime, no divisor
            res_prime_d  = 1'b0;
            res_factor_d = '0;
            state_d      = ST_FIN;
          end else begin
            // Start with divisor two
            dvs_d        = FIRST_DIV;
            div_start    = 1'b1;
            div_dividend = cand_n;
            div_divisor  = FIRST_DIV;
            state_d      = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (div_done) begin
          if (dvs_q > div_quot) begin
            // Divisor passed the square root: prime
            res_prime_d  = 1'b1;
            res_factor_d = num_q;
            state_d      = ST_FIN;
          end else if (div_rem == '0) begin
            res_prime_d  = 1'b0;
            res_factor_d = dvs_q;
            state_d      = ST_FIN;
          end else begin
            // Advance to the next divisor and divide again
            dvs_d       = dvs_q + NUM_WIDTH'(1);
            div_start   = 1'b1;
            div_divisor = dvs_q + NUM_WIDTH'(1);
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register: load a new result, drop it once taken
  always_comb begin
    out_valid_d  = out_valid_q;
    out_prime_d  = out_prime_q;
    out_factor_d = out_factor_q;
    if (out_load) begin
      out_valid_d  = 1'b1;
      out_prime_d  = res_prime_q;
      out_factor_d = factor_fit;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q        <= num_d;
    dvs_q        <= dvs_d;
    res_prime_q  <= res_prime_d;
    res_factor_q <= res_factor_d;
    out_prime_q  <= out_prime_d;
    out_factor_q <= out_factor_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.is_prime     = out_prime_q;
  assign out_o.least_factor = out_factor_q;

  // A division finishes only while the sequencer waits for it
  `TDPT_ASSERT_IMPL(a_done_in_run, clk_i, rst_ni, div_done, state_q == ST_RUN)
  // The trial divisor never drops below two while dividing
  `TDPT_ASSERT_IMPL(a_dvs_min, clk_i, rst_ni, state_q == ST_RUN, dvs_q >= FIRST_DIV)
  // A prime result always names the number itself
  `TDPT_ASSERT_IMPL(a_prime_self, clk_i, rst_ni, out_load && res_prime_q,
                    res_factor_q == num_q)
  // No new division starts once the result is settled
  `TDPT_ASSERT_NEVER(a_no_start_fin, clk_i, rst_ni, div_start && state_q == ST_FIN)

endmodule

>>> src/tdpt_div.sv
// ----------------------------------------------------------------------------
// Trial division prime test - serial divider
// Restoring divider, one quotient bit per cycle; done pulses one cycle.
// ----------------------------------------------------------------------------
module tdpt_div import tdpt_pkg::*; #(
  parameter int unsigned NUM_WIDTH = NUM_W_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [NUM_WIDTH-1:0] dividend_i,
  input  logic [NUM_WIDTH-1:0] divisor_i,
  output logic                 done_o,
  output logic [NUM_WIDTH-1:0] quotient_o,
  output logic [NUM_WIDTH-1:0] remainder_o
);

  localparam int unsigned CNT_W = $clog2(NUM_WIDTH + 1);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [NUM_WIDTH-1:0] dvd_q, dvd_d;
  logic [NUM_WIDTH-1:0] dvs_q, dvs_d;
  logic [NUM_WIDTH-1:0] rem_q, rem_d;

  logic [NUM_WIDTH:0]   trial;
  logic [NUM_WIDTH:0]   diff;
  logic                 borrow;

  // Shift in the next dividend bit and try the subtract
  assign trial  = {rem_q, dvd_q[NUM_WIDTH-1]};
  assign diff   = trial - {1'b0, dvs_q};
  assign borrow = diff[NUM_WIDTH];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NUM_WIDTH);
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // Keep the remainder on borrow, take the difference otherwise
      rem_d = borrow ? trial[NUM_WIDTH-1:0] : diff[NUM_WIDTH-1:0];
      dvd_d = {dvd_q[NUM_WIDTH-2:0], ~borrow};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = dvd_q;
  assign remainder_o = rem_q;

endmodule
